// File: design/rpcr_pkg.sv
// ----------------------------------------------------------------------------
// rpcr_pkg
// Shared widths, register indexes and record types for the RAID parity
// column recovery unit.
// ----------------------------------------------------------------------------
package rpcr_pkg;

  localparam int DISK_W     = 6;   // one bit per disk in a column
  localparam int COL_W      = 6;   // column counter within a stripe
  localparam int DC_W       = 3;   // disk_count register
  localparam int BB_W       = 7;   // block_bits register
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam int COL_LIMIT          = 64;  // columns a COL_W counter can span
  localparam int MAX_DISKS_DEF      = 6;
  localparam int MAX_BLOCK_BITS_DEF = 64;

  localparam logic [DC_W-1:0] DC_RESET = 3'd6;
  localparam logic [BB_W-1:0] BB_RESET = 7'd8;
  localparam logic [DC_W-1:0] DC_MIN   = 3'd2;
  localparam logic [BB_W-1:0] BB_MIN   = 7'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DISK_COUNT = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_PARITY_ODD = 2'd2
  } cfg_reg_t;

  // merge stage verdict on one column
  typedef struct packed {
    logic [DISK_W-1:0] repaired;
    logic              bad;
  } col_check_t;

  // stripe tracking for the column being handled
  typedef struct packed {
    logic [DC_W-1:0] parity_disk;
    logic            stripe_end;
    logic            set_invalid;
  } stripe_stat_t;

  typedef struct packed {
    logic [DISK_W-1:0] repaired_bits;
    logic [DC_W-1:0]   parity_disk;
    logic              column_bad;
    logic              set_invalid;
    logic              stripe_end;
  } result_t;

endpackage

// File: design/rpcr_lane.sv
// ----------------------------------------------------------------------------
// rpcr_lane
// One disk lane: masks the disk's bit and erasure flag by the disk count.
// ----------------------------------------------------------------------------
module rpcr_lane (
  input  logic active,
  input  logic disk_bit,
  input  logic erased,
  output logic good,
  output logic lost
);

  // a disk outside the set contributes nothing
  assign good = active & disk_bit & ~erased;
  assign lost = active & erased;

endmodule

// File: design/rpcr_merge.sv
// ----------------------------------------------------------------------------
// rpcr_merge
// Combines the lanes: erasure count, column XOR, single-bit rebuild and
// the bad-column verdict.
// ----------------------------------------------------------------------------
module rpcr_merge (
  input  logic [rpcr_pkg::DISK_W-1:0] good_vec,
  input  logic [rpcr_pkg::DISK_W-1:0] lost_vec,
  input  logic                        parity_odd,
  output rpcr_pkg::col_check_t        check
);
  import rpcr_pkg::*;

  logic none_lost;
  logic one_lost;
  logic column_xor;
  logic rebuilt;

  assign none_lost  = (lost_vec == '0);
  assign one_lost   = $onehot(lost_vec);
  assign column_xor = ^good_vec;
  assign rebuilt    = column_xor ^ parity_odd;

  always_comb begin
    check.repaired = good_vec;
    check.bad      = 1'b0;
    if (none_lost) begin
      check.bad = (column_xor != parity_odd);
    end else if (one_lost) begin
      check.repaired = good_vec | (rebuilt ? lost_vec : '0);
    end else begin
      check.bad = 1'b1;
    end
  end

endmodule

// File: design/rpcr_stripe_ctr.sv
// ----------------------------------------------------------------------------
// rpcr_stripe_ctr
// Column counter, rotating parity disk index and sticky invalid flag.
// ----------------------------------------------------------------------------
module rpcr_stripe_ctr (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      set_start,
  input  logic                      column_bad,
  input  logic [rpcr_pkg::DC_W-1:0] dc,
  input  logic [rpcr_pkg::BB_W-1:0] bb,
  output rpcr_pkg::stripe_stat_t    stat
);
  import rpcr_pkg::*;

  logic [COL_W-1:0] column_index;
  logic [COL_W-1:0] column_index_next;
  logic [DC_W-1:0]  parity_index;
  logic [DC_W-1:0]  parity_index_next;
  logic             invalid_flag;

  logic [COL_W-1:0] cur_col;
  logic [DC_W-1:0]  cur_par;
  logic             cur_flag;
  logic [DC_W:0]    par_inc;

  // a new set starts from zero before this column is handled
  assign cur_col  = set_start ? '0 : column_index;
  assign cur_par  = set_start ? '0 : parity_index;
  assign cur_flag = set_start ? 1'b0 : invalid_flag;

  always_comb begin
    stat.parity_disk = (cur_par >= dc) ? '0 : cur_par;
    stat.stripe_end  = ({1'b0, cur_col} >= (bb - BB_MIN));
    stat.set_invalid = cur_flag | column_bad;
    par_inc          = {1'b0, stat.parity_disk} + {{DC_W{1'b0}}, 1'b1};
    if (stat.stripe_end) begin
      column_index_next = '0;
      parity_index_next = (par_inc >= {1'b0, dc}) ? '0 : par_inc[DC_W-1:0];
    end else begin
      column_index_next = cur_col + {{(COL_W-1){1'b0}}, 1'b1};
      parity_index_next = stat.parity_disk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      parity_index <= '0;
      invalid_flag <= 1'b0;
    end else if (advance) begin
      column_index <= column_index_next;
      parity_index <= parity_index_next;
      invalid_flag <= stat.set_invalid;
    end
  end

endmodule

// File: design/raid_parity_column_recovery_unit.sv
// ----------------------------------------------------------------------------
// raid_parity_column_recovery_unit
// Checks one bit column of a RAID stripe per request, rebuilds a single
// erased bit from XOR parity, tracks the rotating parity disk and a sticky
// invalid flag for the disk set.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_*       in         tdata: disk_bits[5:0], erased_mask[11:6]; tuser: set_start
//  m_*       out        tdata: repaired_bits[5:0], parity_disk[8:6];
//                       tuser: column_bad[0], set_invalid[1]; tlast: stripe_end
//  cfg_*     in         write: 0 num_disks, 1 block_bits, 2 parity_odd
//
// One column per cycle while s_tready is high; each result is registered.
// The disk lanes and the merge stage are combinational logic ahead of the
// output register, and the stripe counters update at acceptance.
// A skid register behind the output register keeps s_tready high when the
// output is first held; s_tready drops only while the skid is full.
// rst clears the counters, the flag and both output stages, and loads the
// register reset values (6 disks, 8 bits per block, even parity).
// ----------------------------------------------------------------------------
module raid_parity_column_recovery_unit #(
  parameter int MAX_DISKS      = rpcr_pkg::MAX_DISKS_DEF,
  parameter int MAX_BLOCK_BITS = rpcr_pkg::MAX_BLOCK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // disk_bits, erased_mask
  input  logic                            s_tuser,   // set_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // repaired_bits, parity_disk
  output logic [1:0]                      m_tuser,   // column_bad, set_invalid
  output logic                            m_tlast,   // stripe_end
  input  logic                            cfg_we,
  input  logic [rpcr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rpcr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpcr_pkg::*;

  localparam int LANES  = (MAX_DISKS < DISK_W) ? MAX_DISKS : DISK_W;
  localparam int BB_TOP = (MAX_BLOCK_BITS < COL_LIMIT) ? MAX_BLOCK_BITS : COL_LIMIT;
  localparam logic [DC_W-1:0] DC_MAX = DC_W'(LANES);
  localparam logic [BB_W-1:0] BB_MAX = BB_W'(BB_TOP);

  logic [DC_W-1:0] num_disks;
  logic [BB_W-1:0] block_bits;
  logic            parity_odd;
  logic [DC_W-1:0] dc;
  logic [BB_W-1:0] bb;

  logic [DISK_W-1:0] disk_bits;
  logic [DISK_W-1:0] erased_mask;
  logic [DISK_W-1:0] good_vec;
  logic [DISK_W-1:0] lost_vec;
  logic              in_fire;
  logic              out_fire;

  col_check_t   check;
  stripe_stat_t stat;
  result_t      new_res;
  result_t      out_res;
  result_t      skid_res;
  logic         out_valid;
  logic         skid_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_disks  <= DC_RESET;
      block_bits <= BB_RESET;
      parity_odd <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DISK_COUNT: num_disks  <= cfg_data[DC_W-1:0];
        REG_BLOCK_BITS: block_bits <= cfg_data[BB_W-1:0];
        REG_PARITY_ODD: parity_odd <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign dc = (num_disks < DC_MIN) ? DC_MIN : (num_disks > DC_MAX) ? DC_MAX : num_disks;
  assign bb = (block_bits < BB_MIN) ? BB_MIN : (block_bits > BB_MAX) ? BB_MAX : block_bits;

  assign disk_bits   = s_tdata[DISK_W-1:0];
  assign erased_mask = s_tdata[2*DISK_W-1:DISK_W];
  assign in_fire     = s_tvalid & s_tready;
  assign out_fire    = out_valid & m_tready;

  for (genvar j = 0; j < DISK_W; j++) begin : g_lane
    if (j < LANES) begin : g_on
      rpcr_lane u_lane (
        .active   (DC_W'(j) < dc),
        .disk_bit (disk_bits[j]),
        .erased   (erased_mask[j]),
        .good     (good_vec[j]),
        .lost     (lost_vec[j])
      );
    end else begin : g_off
      assign good_vec[j] = 1'b0;
      assign lost_vec[j] = 1'b0;
    end
  end

  rpcr_merge u_merge (
    .good_vec   (good_vec),
    .lost_vec   (lost_vec),
    .parity_odd (parity_odd),
    .check      (check)
  );

  rpcr_stripe_ctr u_ctr (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_fire),
    .set_start  (s_tuser),
    .column_bad (check.bad),
    .dc         (dc),
    .bb         (bb),
    .stat       (stat)
  );

  always_comb begin
    new_res.repaired_bits = check.repaired;
    new_res.parity_disk   = stat.parity_disk;
    new_res.column_bad    = check.bad;
    new_res.set_invalid   = stat.set_invalid;
    new_res.stripe_end    = stat.stripe_end;
  end

  assign s_tready = ~skid_valid;

  // output register with skid: hold the new result in the skid while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_fire) begin
        out_res <= new_res;
      end
    end else if (in_fire) begin
      skid_res <= new_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.parity_disk, out_res.repaired_bits};
  assign m_tuser  = {out_res.set_invalid, out_res.column_bad};
  assign m_tlast  = out_res.stripe_end;

  // the skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full while output register empty");

  // a full skid moves into the output register once the output is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (out_valid && !skid_valid))
    else $error("skid did not drain");

  // a bad column leaves the sticky flag set
  a_bad_sticky: assert property (@(posedge clk) disable iff (rst)
    (in_fire && check.bad) |=> u_ctr.invalid_flag)
    else $error("bad column did not set the invalid flag");

  // the parity disk reported is always inside the disk set
  a_pdisk_range: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (stat.parity_disk < dc))
    else $error("parity disk outside the disk set");

endmodule
